### hw/rtl/lcae_pkg.sv
// ----------------------------------------------------------------------------
// lcae_pkg: shared types and constants of the LED comet animation engine
// Field widths, register map, request codes, sequencer states, slot entry.
// ----------------------------------------------------------------------------
package lcae_pkg;

  localparam int unsigned MAX_PIXELS_DEF  = 512;
  localparam int unsigned COMET_SLOTS_DEF = 8;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned GAP_W   = 9;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned KEEP_W  = 8;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STRIP_W = 2;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned CH_W    = 8;

  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IW  = 3;

  localparam logic [GAP_W-1:0]  GAP_ONE_RST     = GAP_W'(61);
  localparam logic [GAP_W-1:0]  GAP_TWO_RST     = GAP_W'(122);
  localparam logic [GAP_W-1:0]  GAP_THREE_RST   = GAP_W'(183);
  localparam logic [CNT_W-1:0]  PIXEL_COUNT_RST = CNT_W'(244);
  localparam logic [KEEP_W-1:0] KEEP_SCALE_RST  = KEEP_W'(171);

  typedef enum logic [REG_IW-1:0] {
    REG_GAP_ONE     = 3'd0,
    REG_GAP_TWO     = 3'd1,
    REG_GAP_THREE   = 3'd2,
    REG_PIXEL_COUNT = 3'd3,
    REG_KEEP_SCALE  = 3'd4
  } lcae_reg_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_SPAWN = 2'd1,
    REQ_READ  = 2'd2
  } lcae_req_e;

  typedef enum logic [STRIP_W-1:0] {
    STRIP_0 = 2'd0,
    STRIP_1 = 2'd1,
    STRIP_2 = 2'd2,
    STRIP_3 = 2'd3
  } lcae_strip_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FADE,
    ST_FADE_LAST,
    ST_COMET,
    ST_SPAWN,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } lcae_state_e;

  typedef struct packed {
    logic               active;
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } lcae_slot_t;

endpackage

### hw/rtl/lcae_req_if.sv
// ----------------------------------------------------------------------------
// lcae_req_if: request channel of the comet engine
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface lcae_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcae_pkg::REQ_W-1:0]    req_type;
  logic [lcae_pkg::COLOR_W-1:0]  comet_color;
  logic [lcae_pkg::STRIP_W-1:0]  strip_select;
  logic                          travel_reverse;
  logic [lcae_pkg::IDX_W-1:0]    pixel_index;

  modport source (
    output valid, req_type, comet_color, strip_select, travel_reverse, pixel_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, comet_color, strip_select, travel_reverse, pixel_index,
    output ready
  );
endinterface

### hw/rtl/lcae_rsp_if.sv
// ----------------------------------------------------------------------------
// lcae_rsp_if: response channel of the comet engine
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface lcae_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lcae_pkg::COLOR_W-1:0]  pixel_color;
  logic                          spawn_taken;

  modport source (
    output valid, pixel_color, spawn_taken,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, spawn_taken,
    output ready
  );
endinterface

### hw/rtl/lcae_fade_unit.sv
// ----------------------------------------------------------------------------
// lcae_fade_unit: per-channel brightness scaling
// Scale each colour channel by (keep+1)/256.
// ----------------------------------------------------------------------------
module lcae_fade_unit (
  input  logic [lcae_pkg::COLOR_W-1:0] color_i,
  input  logic [lcae_pkg::KEEP_W-1:0]  keep_i,
  output logic [lcae_pkg::COLOR_W-1:0] color_o
);

  localparam int unsigned NCH  = lcae_pkg::COLOR_W / lcae_pkg::CH_W;
  localparam int unsigned K_W  = lcae_pkg::KEEP_W + 1;
  localparam int unsigned PR_W = lcae_pkg::CH_W + K_W;

  logic [K_W-1:0] k;

  assign k = K_W'(keep_i) + K_W'(1);

  for (genvar g = 0; g < NCH; g++) begin : g_ch
    logic [PR_W-1:0] prod;
    assign prod = PR_W'(color_i[g*lcae_pkg::CH_W +: lcae_pkg::CH_W]) * PR_W'(k);
    assign color_o[g*lcae_pkg::CH_W +: lcae_pkg::CH_W] = prod[lcae_pkg::CH_W +: lcae_pkg::CH_W];
  end

endmodule

### hw/rtl/lcae_frame_mem.sv
// ----------------------------------------------------------------------------
// lcae_frame_mem: pixel frame buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcae_frame_mem #(
  parameter int unsigned DEPTH = lcae_pkg::MAX_PIXELS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [lcae_pkg::COLOR_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [lcae_pkg::COLOR_W-1:0] rdata_o
);

  logic [lcae_pkg::COLOR_W-1:0] mem_q [DEPTH];
  logic [lcae_pkg::COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lcae_slot_table.sv
// ----------------------------------------------------------------------------
// lcae_slot_table: forward and reverse comet slot tables
// One read and one write per cycle, addressed by direction and slot.
// ----------------------------------------------------------------------------
module lcae_slot_table #(
  parameter int unsigned SLOTS = lcae_pkg::COMET_SLOTS_DEF,
  parameter int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_dir_i,
  input  logic [SW-1:0]       rd_slot_i,
  output lcae_pkg::lcae_slot_t rd_entry_o,
  input  logic                we_i,
  input  logic                wr_dir_i,
  input  logic [SW-1:0]       wr_slot_i,
  input  lcae_pkg::lcae_slot_t wr_entry_i
);

  logic [SLOTS-1:0]                fwd_act_q, rev_act_q;
  logic [lcae_pkg::POS_W-1:0]      fwd_pos_q [SLOTS];
  logic [lcae_pkg::POS_W-1:0]      rev_pos_q [SLOTS];
  logic [lcae_pkg::COLOR_W-1:0]    fwd_col_q [SLOTS];
  logic [lcae_pkg::COLOR_W-1:0]    rev_col_q [SLOTS];

  // Active bits: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_act_q <= '0;
      rev_act_q <= '0;
    end else if (we_i) begin
      if (wr_dir_i) begin
        rev_act_q[wr_slot_i] <= wr_entry_i.active;
      end else begin
        fwd_act_q[wr_slot_i] <= wr_entry_i.active;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      if (wr_dir_i) begin
        rev_pos_q[wr_slot_i] <= wr_entry_i.pos;
        rev_col_q[wr_slot_i] <= wr_entry_i.color;
      end else begin
        fwd_pos_q[wr_slot_i] <= wr_entry_i.pos;
        fwd_col_q[wr_slot_i] <= wr_entry_i.color;
      end
    end
  end

  always_comb begin
    if (rd_dir_i) begin
      rd_entry_o.active = rev_act_q[rd_slot_i];
      rd_entry_o.pos    = rev_pos_q[rd_slot_i];
      rd_entry_o.color  = rev_col_q[rd_slot_i];
    end else begin
      rd_entry_o.active = fwd_act_q[rd_slot_i];
      rd_entry_o.pos    = fwd_pos_q[rd_slot_i];
      rd_entry_o.color  = fwd_col_q[rd_slot_i];
    end
  end

endmodule

### hw/rtl/led_comet_animation_engine.sv
// ----------------------------------------------------------------------------
// led_comet_animation_engine: LED strip frame buffer with travelling comets
// Frame tick: a fade sweep (one pixel a cycle through the buffer's read and
//   write ports) followed by a walk over the forward and reverse slots; spawn
//   scans the slots in order for a free one; a pixel read waits on the registered read.
// Throughput: one item at a time; result visible the cycle after completion.
// Reset: asynchronous; a clearing pass zeroes the buffer while requests are
//   held off; slots reset free, registers to defaults.
// ----------------------------------------------------------------------------
module led_comet_animation_engine #(
  parameter int unsigned MAX_PIXELS  = lcae_pkg::MAX_PIXELS_DEF,
  parameter int unsigned COMET_SLOTS = lcae_pkg::COMET_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lcae_req_if.sink                     req_i,
  lcae_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcae_pkg::APB_AW-1:0]  paddr,
  input  logic [lcae_pkg::APB_DW-1:0]  pwdata,
  output logic [lcae_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned AW   = $clog2(MAX_PIXELS);
  localparam int unsigned SW   = (COMET_SLOTS > 1) ? $clog2(COMET_SLOTS) : 1;
  // Largest bound the 10-bit pixel count can ever select
  localparam int unsigned MAXC = (MAX_PIXELS > 1023) ? 1023 : MAX_PIXELS;
  localparam int unsigned CW   = lcae_pkg::COLOR_W;
  localparam int unsigned PW   = lcae_pkg::POS_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [lcae_pkg::GAP_W-1:0]  gap_one_q, gap_two_q, gap_three_q;
  logic [lcae_pkg::CNT_W-1:0]  pixel_count_q;
  logic [lcae_pkg::KEEP_W-1:0] keep_scale_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_one_q     <= lcae_pkg::GAP_ONE_RST;
      gap_two_q     <= lcae_pkg::GAP_TWO_RST;
      gap_three_q   <= lcae_pkg::GAP_THREE_RST;
      pixel_count_q <= lcae_pkg::PIXEL_COUNT_RST;
      keep_scale_q  <= lcae_pkg::KEEP_SCALE_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lcae_pkg::REG_GAP_ONE:     gap_one_q     <= pwdata[lcae_pkg::GAP_W-1:0];
        lcae_pkg::REG_GAP_TWO:     gap_two_q     <= pwdata[lcae_pkg::GAP_W-1:0];
        lcae_pkg::REG_GAP_THREE:   gap_three_q   <= pwdata[lcae_pkg::GAP_W-1:0];
        lcae_pkg::REG_PIXEL_COUNT: pixel_count_q <= pwdata[lcae_pkg::CNT_W-1:0];
        lcae_pkg::REG_KEEP_SCALE:  keep_scale_q  <= pwdata[lcae_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lcae_pkg::REG_GAP_ONE:     prdata = lcae_pkg::APB_DW'(gap_one_q);
      lcae_pkg::REG_GAP_TWO:     prdata = lcae_pkg::APB_DW'(gap_two_q);
      lcae_pkg::REG_GAP_THREE:   prdata = lcae_pkg::APB_DW'(gap_three_q);
      lcae_pkg::REG_PIXEL_COUNT: prdata = lcae_pkg::APB_DW'(pixel_count_q);
      lcae_pkg::REG_KEEP_SCALE:  prdata = lcae_pkg::APB_DW'(keep_scale_q);
      default:                   prdata = '0;
    endcase
  end

  // Effective bound: smaller of pixel count and buffer depth
  logic [lcae_pkg::CNT_W-1:0] bound;
  assign bound = (pixel_count_q < lcae_pkg::CNT_W'(MAXC)) ? pixel_count_q
                                                           : lcae_pkg::CNT_W'(MAXC);

  function automatic logic is_gap(input logic [lcae_pkg::POS_W-1:0] p,
                                  input logic [lcae_pkg::GAP_W-1:0] g1,
                                  input logic [lcae_pkg::GAP_W-1:0] g2,
                                  input logic [lcae_pkg::GAP_W-1:0] g3);
    return (p == lcae_pkg::POS_W'(g1)) || (p == lcae_pkg::POS_W'(g2)) ||
           (p == lcae_pkg::POS_W'(g3));
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer state and captured request
  // --------------------------------------------------------------------------
  lcae_pkg::lcae_state_e         state_q, state_d;
  logic [AW-1:0]                 pix_cnt_q, pix_cnt_d;
  logic [SW-1:0]                 slot_q, slot_d;
  logic                          dir_q, dir_d;
  logic                          fade_pend_q;
  logic [AW-1:0]                 fade_addr_q;
  logic [CW-1:0]                 color_q;
  logic [lcae_pkg::STRIP_W-1:0]  strip_q;
  logic [lcae_pkg::IDX_W-1:0]    idx_q;
  logic                          in_range_q, in_range_d;
  logic [CW-1:0]                 res_color_q, res_color_d;
  logic                          res_taken_q, res_taken_d;
  logic                          out_valid_q;
  logic [CW-1:0]                 out_color_q;
  logic                          out_taken_q;
  logic                          out_load;
  logic                          req_acc;

  // Buffer and slot table controls
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [CW-1:0]                 mem_wdata, mem_rdata, faded;
  lcae_pkg::lcae_slot_t          slot_rd, slot_wr;
  logic                          slot_we;

  // Spawn start position and its range check
  logic [PW-1:0]                 start_pos;
  logic                          start_neg;
  logic                          start_ok;
  logic [PW-1:0]                 base_pos;

  // Step of the comet under the slot walk
  logic [PW-1:0]                 step_pos;
  logic                          stale;

  assign req_i.ready = (state_q == lcae_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  lcae_frame_mem #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lcae_fade_unit u_fade_unit (
    .color_i (mem_rdata),
    .keep_i  (keep_scale_q),
    .color_o (faded)
  );

  lcae_slot_table #(
    .SLOTS (COMET_SLOTS),
    .SW    (SW)
  ) u_slot_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_dir_i   (dir_q),
    .rd_slot_i  (slot_q),
    .rd_entry_o (slot_rd),
    .we_i       (slot_we),
    .wr_dir_i   (dir_q),
    .wr_slot_i  (slot_q),
    .wr_entry_i (slot_wr)
  );

  // Start position: strip start going forward, strip end going in reverse
  always_comb begin
    case (strip_q)
      lcae_pkg::STRIP_0: base_pos = dir_q ? PW'(gap_one_q)   : '0;
      lcae_pkg::STRIP_1: base_pos = dir_q ? PW'(gap_two_q)   : PW'(gap_one_q);
      lcae_pkg::STRIP_2: base_pos = dir_q ? PW'(gap_three_q) : PW'(gap_two_q);
      lcae_pkg::STRIP_3: base_pos = dir_q ? pixel_count_q    : PW'(gap_three_q);
      default:           base_pos = '0;
    endcase
    if (dir_q) begin
      start_neg = (base_pos == '0);
      start_pos = base_pos - PW'(1);
    end else begin
      start_neg = 1'b0;
      start_pos = (strip_q == lcae_pkg::STRIP_0) ? '0 : base_pos + PW'(1);
    end
    start_ok = !start_neg && (start_pos < bound);
  end

  assign stale    = (slot_rd.pos >= bound);
  assign step_pos = dir_q ? slot_rd.pos - PW'(1) : slot_rd.pos + PW'(1);

  // --------------------------------------------------------------------------
  // Next state and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    pix_cnt_d   = pix_cnt_q;
    slot_d      = slot_q;
    dir_d       = dir_q;
    in_range_d  = in_range_q;
    res_color_d = res_color_q;
    res_taken_d = res_taken_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = fade_addr_q;
    mem_wdata   = faded;
    mem_raddr   = pix_cnt_q;
    slot_we     = 1'b0;
    slot_wr     = slot_rd;

    // Write back the pixel read in the previous fade cycle
    if (fade_pend_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      lcae_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_cnt_q;
        mem_wdata = '0;
        pix_cnt_d = pix_cnt_q + AW'(1);
        if (pix_cnt_q == AW'(MAX_PIXELS - 1)) begin
          pix_cnt_d = '0;
          state_d   = lcae_pkg::ST_IDLE;
        end
      end

      lcae_pkg::ST_IDLE: begin
        if (req_acc) begin
          pix_cnt_d   = '0;
          slot_d      = '0;
          res_color_d = '0;
          res_taken_d = 1'b0;
          in_range_d  = (32'(req_i.pixel_index) < 32'(MAX_PIXELS));
          case (req_i.req_type)
            lcae_pkg::REQ_TICK: begin
              dir_d   = 1'b0;
              state_d = lcae_pkg::ST_FADE;
            end
            lcae_pkg::REQ_SPAWN: begin
              dir_d   = req_i.travel_reverse;
              state_d = lcae_pkg::ST_SPAWN;
            end
            lcae_pkg::REQ_READ: begin
              state_d = lcae_pkg::ST_READ;
            end
            default: begin
              state_d = lcae_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Read one pixel a cycle; its faded value is written back in the next cycle
      lcae_pkg::ST_FADE: begin
        pix_cnt_d = pix_cnt_q + AW'(1);
        if (pix_cnt_q == AW'(MAX_PIXELS - 1)) begin
          pix_cnt_d = '0;
          state_d   = lcae_pkg::ST_FADE_LAST;
        end
      end

      lcae_pkg::ST_FADE_LAST: begin
        slot_d  = '0;
        dir_d   = 1'b0;
        state_d = lcae_pkg::ST_COMET;
      end

      // Walk forward slots, then reverse slots: paint, step, free
      lcae_pkg::ST_COMET: begin
        if (slot_rd.active) begin
          slot_we = 1'b1;
          if (stale) begin
            slot_wr.active = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(slot_rd.pos);
            mem_wdata = slot_rd.color;
            if (dir_q) begin
              if (slot_rd.pos == '0) begin
                slot_wr.active = 1'b0;
              end else begin
                slot_wr.pos    = step_pos;
                slot_wr.active = !is_gap(step_pos, gap_one_q, gap_two_q, gap_three_q);
              end
            end else begin
              slot_wr.pos    = step_pos;
              slot_wr.active = !((step_pos >= bound) ||
                                 is_gap(step_pos, gap_one_q, gap_two_q, gap_three_q));
            end
          end
        end
        slot_d = slot_q + SW'(1);
        if (slot_q == SW'(COMET_SLOTS - 1)) begin
          slot_d = '0;
          if (dir_q) begin
            state_d = lcae_pkg::ST_DONE;
          end else begin
            dir_d = 1'b1;
          end
        end
      end

      // Scan for the lowest free slot of the chosen direction
      lcae_pkg::ST_SPAWN: begin
        if (!start_ok) begin
          state_d = lcae_pkg::ST_DONE;
        end else if (!slot_rd.active) begin
          slot_we        = 1'b1;
          slot_wr.active = 1'b1;
          slot_wr.pos    = start_pos;
          slot_wr.color  = color_q;
          res_taken_d    = 1'b1;
          state_d        = lcae_pkg::ST_DONE;
        end else if (slot_q == SW'(COMET_SLOTS - 1)) begin
          state_d = lcae_pkg::ST_DONE;
        end else begin
          slot_d = slot_q + SW'(1);
        end
      end

      lcae_pkg::ST_READ: begin
        mem_raddr = AW'(idx_q);
        state_d   = lcae_pkg::ST_READ_WAIT;
      end

      lcae_pkg::ST_READ_WAIT: begin
        res_color_d = in_range_q ? mem_rdata : '0;
        state_d     = lcae_pkg::ST_DONE;
      end

      // Hand the result over once the output register is free
      lcae_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = lcae_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lcae_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcae_pkg::ST_CLEAR;
      pix_cnt_q   <= '0;
      slot_q      <= '0;
      dir_q       <= 1'b0;
      fade_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pix_cnt_q   <= pix_cnt_d;
      slot_q      <= slot_d;
      dir_q       <= dir_d;
      fade_pend_q <= (state_q == lcae_pkg::ST_FADE);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    fade_addr_q <= pix_cnt_q;
    in_range_q  <= in_range_d;
    res_color_q <= res_color_d;
    res_taken_q <= res_taken_d;
    if (req_acc) begin
      color_q    <= req_i.comet_color;
      strip_q    <= req_i.strip_select;
      idx_q      <= req_i.pixel_index;
    end
    if (out_load) begin
      out_color_q <= res_color_q;
      out_taken_q <= res_taken_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_color = out_color_q;
  assign rsp_o.spawn_taken = out_taken_q;

endmodule

### tb/led_comet_animation_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_comet_animation_engine_tb: self-checking bench for the comet engine
// Drives ticks, spawns and pixel reads through the request channel under
// bursty traffic and a stalling receiver. Each reply is compared with a typed
// expectation or a cycle-free copy of the engine kept in the bench. Register
// settings change between phases, from reset defaults out to the range limits.
// ----------------------------------------------------------------------------
module led_comet_animation_engine_tb;
  import lcae_pkg::*;

  localparam int unsigned NPIX   = MAX_PIXELS_DEF;
  localparam int unsigned NSLOT  = COMET_SLOTS_DEF;
  // The fourth request code is unused: the engine must answer it with zeros.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE  = 100;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned LONG_HOLD_AT     = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 2000;
  // A frame tick is the slowest request: fade sweep plus slot walk.
  localparam int unsigned DRAIN_CYCLES     = NPIX + 2 * NSLOT + 16;
  localparam int unsigned CYCLE_LIMIT      = 2_000_000;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               spawn_taken;
  } engine_reply_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [COLOR_W-1:0] color;
    logic [STRIP_W-1:0] strip;
    logic               rev;
    logic [IDX_W-1:0]   idx;
    bit                 typed;
    engine_reply_t      known;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lcae_req_if req_if ();
  lcae_rsp_if rsp_if ();

  led_comet_animation_engine DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if.sink),
    .rsp_o   (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the engine: registers, frame buffer and both slot tables
  // --------------------------------------------------------------------------
  logic [GAP_W-1:0]   gap_one_q, gap_two_q, gap_three_q;
  logic [CNT_W-1:0]   pixel_count_q;
  logic [KEEP_W-1:0]  keep_scale_q;
  logic [COLOR_W-1:0] frame_q [NPIX];
  lcae_slot_t         fwd_slot [NSLOT];
  lcae_slot_t         rev_slot [NSLOT];

  engine_reply_t replies_due [$];
  stim_row_t     directed_rows [$];
  int unsigned   err_count;
  int unsigned   replies_seen;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  function automatic int unsigned live_bound();
    return (pixel_count_q < NPIX) ? int'(pixel_count_q) : NPIX;
  endfunction

  function automatic bit on_gap(int unsigned p);
    return p == gap_one_q || p == gap_two_q || p == gap_three_q;
  endfunction

  // Scale each channel by (keep+1)/256, rounding down.
  function automatic logic [COLOR_W-1:0] dim_color(logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    int unsigned        ch;
    int unsigned        k;
    k = keep_scale_q + 1;
    for (int s = 0; s < 3; s++) begin
      ch = c[s*CH_W +: CH_W];
      r[s*CH_W +: CH_W] = CH_W'((ch * k) >> 8);
    end
    return r;
  endfunction

  // Fade the whole buffer, then let forward comets paint and step up, then
  // reverse comets paint and step down, each table in slot order.
  function automatic void advance_frame();
    int unsigned n;
    int unsigned p;
    n = live_bound();
    for (int i = 0; i < NPIX; i++) frame_q[i] = dim_color(frame_q[i]);
    for (int i = 0; i < NSLOT; i++) begin
      if (fwd_slot[i].active) begin
        p = fwd_slot[i].pos;
        if (p >= n) begin
          // stranded past a lowered bound: drop without painting
          fwd_slot[i].active = 1'b0;
        end else begin
          frame_q[p] = fwd_slot[i].color;
          p++;
          fwd_slot[i].pos = POS_W'(p);
          if (p >= n || on_gap(p)) fwd_slot[i].active = 1'b0;
        end
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (rev_slot[i].active) begin
        p = rev_slot[i].pos;
        if (p >= n) begin
          rev_slot[i].active = 1'b0;
        end else begin
          frame_q[p] = rev_slot[i].color;
          if (p == 0) begin
            rev_slot[i].active = 1'b0;
          end else begin
            p--;
            rev_slot[i].pos = POS_W'(p);
            if (on_gap(p)) rev_slot[i].active = 1'b0;
          end
        end
      end
    end
  endfunction

  // Claim the lowest free slot of the chosen direction at the strip's end.
  function automatic logic claim_slot(logic [COLOR_W-1:0] color,
                                      logic [STRIP_W-1:0] strip, logic rev);
    int start;
    if (!rev) begin
      case (strip)
        STRIP_0: start = 0;
        STRIP_1: start = int'(gap_one_q) + 1;
        STRIP_2: start = int'(gap_two_q) + 1;
        default: start = int'(gap_three_q) + 1;
      endcase
    end else begin
      case (strip)
        STRIP_0: start = int'(gap_one_q) - 1;
        STRIP_1: start = int'(gap_two_q) - 1;
        STRIP_2: start = int'(gap_three_q) - 1;
        default: start = int'(pixel_count_q) - 1;
      endcase
    end
    // start off the strip: drop even with a free slot
    if (start < 0 || start >= int'(live_bound())) return 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!rev && !fwd_slot[i].active) begin
        fwd_slot[i] = '{active: 1'b1, pos: POS_W'(start), color: color};
        return 1'b1;
      end
      if (rev && !rev_slot[i].active) begin
        rev_slot[i] = '{active: 1'b1, pos: POS_W'(start), color: color};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic engine_reply_t compute_reply(logic [REQ_W-1:0] req,
                                                  logic [COLOR_W-1:0] color,
                                                  logic [STRIP_W-1:0] strip,
                                                  logic rev, logic [IDX_W-1:0] idx);
    engine_reply_t r;
    r = '0;
    case (req)
      REQ_TICK:  advance_frame();
      REQ_SPAWN: r.spawn_taken = claim_slot(color, strip, rev);
      REQ_READ:  if (idx < NPIX) r.pixel_color = frame_q[idx];
      default:   ;
    endcase
    return r;
  endfunction

  // Aim most reads at or beside a comet so painted pixels get looked at.
  function automatic logic [IDX_W-1:0] pick_read_index();
    int unsigned p;
    int unsigned k;
    if ($urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, NSLOT - 1);
      p = $urandom_range(0, 1) ? fwd_slot[k].pos : rev_slot[k].pos;
      p = p + $urandom_range(0, 2) - 1;
      return IDX_W'(p);
    end
    return IDX_W'($urandom_range(0, NPIX - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[led_comet_animation_engine] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Every task below starts and ends just after a rising edge.
  // --------------------------------------------------------------------------
  task automatic put_row(logic [REQ_W-1:0] req, logic [COLOR_W-1:0] color,
                         logic [STRIP_W-1:0] strip, logic rev, logic [IDX_W-1:0] idx,
                         bit typed, logic [COLOR_W-1:0] pix, logic taken);
    stim_row_t row;
    row = '{req: req, color: color, strip: strip, rev: rev, idx: idx,
            typed: typed, known: '{pixel_color: pix, spawn_taken: taken}};
    directed_rows.push_back(row);
  endtask

  // Offer one item, hold it until taken, then log what the engine should say.
  // Between bursts, drop valid for a random gap.
  task automatic send_request(logic [REQ_W-1:0] req, logic [COLOR_W-1:0] color,
                              logic [STRIP_W-1:0] strip, logic rev,
                              logic [IDX_W-1:0] idx, bit typed, engine_reply_t known);
    engine_reply_t want;
    req_if.valid          <= 1'b1;
    req_if.req_type       <= req;
    req_if.comet_color    <= color;
    req_if.strip_select   <= strip;
    req_if.travel_reverse <= rev;
    req_if.pixel_index    <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    want = compute_reply(req, color, strip, rev, idx);
    replies_due.push_back(typed ? known : want);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // now and then run a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 16);
    end
  endtask

  task automatic send_random_item();
    logic [REQ_W-1:0] req;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 28)      req = REQ_TICK;
    else if (pick < 58) req = REQ_SPAWN;
    else if (pick < 95) req = REQ_READ;
    else                req = REQ_UNUSED;
    send_request(req, COLOR_W'($urandom()), STRIP_W'($urandom()), 1'($urandom()),
                 (req == REQ_READ) ? pick_read_index() : IDX_W'($urandom()),
                 1'b0, '0);
  endtask

  // APB write: setup cycle, then access cycle completing on pready.
  task automatic write_reg(lcae_reg_e r, logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_GAP_ONE:     gap_one_q     = v[GAP_W-1:0];
      REG_GAP_TWO:     gap_two_q     = v[GAP_W-1:0];
      REG_GAP_THREE:   gap_three_q   = v[GAP_W-1:0];
      REG_PIXEL_COUNT: pixel_count_q = v[CNT_W-1:0];
      REG_KEEP_SCALE:  keep_scale_q  = v[KEEP_W-1:0];
      default:         ;
    endcase
  endtask

  // Let the engine empty out, then program a whole register set.
  task automatic program_engine(int unsigned g1, int unsigned g2, int unsigned g3,
                                int unsigned cnt, int unsigned keep);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    write_reg(REG_GAP_ONE, g1);
    write_reg(REG_GAP_TWO, g2);
    write_reg(REG_GAP_THREE, g3);
    write_reg(REG_PIXEL_COUNT, cnt);
    write_reg(REG_KEEP_SCALE, keep);
  endtask

  initial begin : request_driver
    int unsigned g1, g2, g3;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= REQ_TICK;
    req_if.comet_color    <= '0;
    req_if.strip_select   <= STRIP_0;
    req_if.travel_reverse <= 1'b0;
    req_if.pixel_index    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    err_count  = 0;
    burst_left = $urandom_range(1, 16);

    gap_one_q     = GAP_ONE_RST;
    gap_two_q     = GAP_TWO_RST;
    gap_three_q   = GAP_THREE_RST;
    pixel_count_q = PIXEL_COUNT_RST;
    keep_scale_q  = KEEP_SCALE_RST;
    for (int i = 0; i < NPIX; i++) frame_q[i] = '0;
    for (int i = 0; i < NSLOT; i++) begin
      fwd_slot[i] = '0;
      rev_slot[i] = '0;
    end

    // Directed part, under reset settings. Typed rows: fresh buffer, unused
    // code, first spawns, first paint, and a forward table that is full.
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd0,   1'b1, 24'h000000, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd511, 1'b1, 24'h000000, 1'b0);
    put_row(REQ_UNUSED, 24'hFFFFFF, STRIP_3, 1'b1, 9'd511, 1'b1, 24'h000000, 1'b0);
    put_row(REQ_SPAWN,  24'hFFFFFF, STRIP_0, 1'b0, 9'd0,   1'b1, 24'h000000, 1'b1);
    put_row(REQ_SPAWN,  24'h000001, STRIP_1, 1'b0, 9'd0,   1'b1, 24'h000000, 1'b1);
    put_row(REQ_SPAWN,  24'h800000, STRIP_3, 1'b1, 9'd0,   1'b1, 24'h000000, 1'b1);
    put_row(REQ_SPAWN,  24'h00FF00, STRIP_0, 1'b1, 9'd0,   1'b1, 24'h000000, 1'b1);
    put_row(REQ_TICK,   24'h000000, STRIP_0, 1'b0, 9'd0,   1'b1, 24'h000000, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd0,   1'b1, 24'hFFFFFF, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd62,  1'b1, 24'h000001, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd243, 1'b1, 24'h800000, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd60,  1'b1, 24'h00FF00, 1'b0);
    put_row(REQ_TICK,   24'hFFFFFF, STRIP_3, 1'b1, 9'd511, 1'b1, 24'h000000, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd1,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'h123456, STRIP_2, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'hABCDEF, STRIP_3, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'h0000FF, STRIP_0, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'hFF0000, STRIP_1, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'h00FFFF, STRIP_2, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'h7F7F7F, STRIP_3, 1'b0, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_SPAWN,  24'h555555, STRIP_0, 1'b0, 9'd0,   1'b1, 24'h000000, 1'b0);
    put_row(REQ_SPAWN,  24'h000000, STRIP_1, 1'b1, 9'd0,   1'b0, '0, 1'b0);
    put_row(REQ_READ,   24'h000000, STRIP_0, 1'b0, 9'd122, 1'b0, '0, 1'b0);

    // Hold off until reset is released; the clearing pass shows as ready low.
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].color, directed_rows[i].strip,
                   directed_rows[i].rev, directed_rows[i].idx, directed_rows[i].typed,
                   directed_rows[i].known);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // tightest gaps, full buffer, no fading
        1: program_engine(1, 2, 3, NPIX, 255);
        // one-pixel buffer, gaps at the top, full fade; strands live comets
        2: program_engine(511, 511, 511, 1, 0);
        3: begin
          g1 = $urandom_range(2, 170);
          g2 = g1 + $urandom_range(2, 170);
          g3 = g2 + $urandom_range(2, 170);
          program_engine(g1, g2, g3, $urandom_range(g3 + 2, NPIX), $urandom_range(0, 255));
        end
        // unordered gaps and any count from 1 to the buffer depth
        4: program_engine($urandom_range(1, 511), $urandom_range(1, 511),
                          $urandom_range(1, 511), $urandom_range(1, NPIX),
                          $urandom_range(0, 255));
        default: ;
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    // Drain, give the engine a tick's worth of cycles for stray replies, then judge.
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[led_comet_animation_engine] OK");
    end else begin
      $display("[led_comet_animation_engine] ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Reply side: check each item, stall on a changing pattern, and once hold
  // off long enough for the engine to back up into the request channel.
  // --------------------------------------------------------------------------
  initial begin : reply_monitor
    int unsigned   hold_left;
    int unsigned   mode;
    int unsigned   mode_left;
    int unsigned   phase_cnt;
    engine_reply_t want;
    rsp_if.ready <= 1'b0;
    replies_seen = 0;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    phase_cnt    = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          $error("reply with nothing outstanding: pixel_color %06h spawn_taken %0b",
                 rsp_if.pixel_color, rsp_if.spawn_taken);
          err_count++;
        end else begin
          want = replies_due.pop_front();
          if (rsp_if.pixel_color !== want.pixel_color) begin
            $error("pixel_color expected %06h actual %06h",
                   want.pixel_color, rsp_if.pixel_color);
            err_count++;
          end
          if (rsp_if.spawn_taken !== want.spawn_taken) begin
            $error("spawn_taken expected %0b actual %0b",
                   want.spawn_taken, rsp_if.spawn_taken);
            err_count++;
          end
        end
        if (replies_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= (phase_cnt % 4 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

endmodule

### led_comet_animation_engine.f
hw/rtl/lcae_pkg.sv
hw/rtl/lcae_req_if.sv
hw/rtl/lcae_rsp_if.sv
hw/rtl/lcae_fade_unit.sv
hw/rtl/lcae_frame_mem.sv
hw/rtl/lcae_slot_table.sv
hw/rtl/led_comet_animation_engine.sv
tb/led_comet_animation_engine_tb.sv
